[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Item types, operation and status codes shared by the front, back and top.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDIV = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	localparam logic signed [63:0] I64_MIN = {1'b1, 63'd0};

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic signed [31:0] res_den;
		logic [1:0]         status;
	} rau_out_t;

	// Classified item as it waits in the queue between front and back.
	typedef struct packed {
		logic [1:0]         op;
		logic               zden;
		logic signed [31:0] an;
		logic signed [31:0] ad;
		logic signed [31:0] bn;
		logic signed [31:0] bd;
	} rau_job_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] dividend;
		logic signed [63:0] divisor;
	} rau_div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] quo;
		logic signed [63:0] rem;
	} rau_div_rsp_t;

endpackage

[rtl/rau_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts items, sign-extends the operands, flags zero denominators for
// add and subtract, and holds classified items in a two-entry queue.
// ----------------------------------------------------------------------------
module rau_front #(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rau_pkg::rau_in_t  req,
	output logic              job_valid,
	output rau_pkg::rau_job_t job,
	input  logic              job_take
);
	import rau_pkg::*;

	localparam int SH = 32 - WIDTH;

	function automatic logic signed [31:0] sx(input logic signed [31:0] v);
		return (v <<< SH) >>> SH;
	endfunction

	rau_job_t   fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	rau_job_t   nj;

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = fifo_q[rp_q];

	always_comb begin
		nj.op   = req.req_type;
		nj.an   = sx(req.a_num);
		nj.ad   = sx(req.a_den);
		nj.bn   = sx(req.b_num);
		nj.bd   = sx(req.b_den);
		nj.zden = ((req.req_type == OP_ADD) || (req.req_type == OP_SUB)) &&
			((nj.ad == 32'sd0) || (nj.bd == 32'sd0));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= nj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (job_take) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(job_take);
		end
	end

endmodule

[rtl/rau_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating
// quotient and remainder with the sign of the dividend.
// ----------------------------------------------------------------------------
module rau_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rau_pkg::rau_div_req_t dreq,
	output rau_pkg::rau_div_rsp_t drsp
);
	import rau_pkg::*;

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] mb_q;
	logic        negq_q;
	logic        negr_q;
	logic [63:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q[62:0], quo_q[63]};
	assign ge     = (rem_sh >= mb_q);

	assign drsp.done = done_q;
	assign drsp.quo  = negq_q ? -$signed(quo_q) : $signed(quo_q);
	assign drsp.rem  = negr_q ? -$signed(rem_q) : $signed(rem_q);

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			quo_q  <= dreq.dividend[63] ? 64'(-dreq.dividend) : 64'(dreq.dividend);
			mb_q   <= dreq.divisor[63] ? 64'(-dreq.divisor) : 64'(dreq.divisor);
			rem_q  <= 64'd0;
			negq_q <= dreq.dividend[63] ^ dreq.divisor[63];
			negr_q <= dreq.dividend[63];
		end else if (run_q) begin
			rem_q <= ge ? (rem_sh - mb_q) : rem_sh;
			quo_q <= {quo_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= run_q && (cnt_q == 6'd63);
			if (dreq.start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
				end
			end
		end
	end

endmodule

[rtl/rau_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Sequencer that carries out one queued item with a shared divider and a
// shared 33x33 multiplier, including Euclid's loop and the reductions.
// ----------------------------------------------------------------------------
module rau_back #(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  rau_pkg::rau_job_t job,
	output logic              job_take,
	output logic              strobe,
	output rau_pkg::rau_out_t res
);
	import rau_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_A1   = 5'd2;
	localparam logic [4:0] S_A2   = 5'd3;
	localparam logic [4:0] S_A3   = 5'd4;
	localparam logic [4:0] S_A4   = 5'd5;
	localparam logic [4:0] S_A5   = 5'd6;
	localparam logic [4:0] S_A6   = 5'd7;
	localparam logic [4:0] S_A7   = 5'd8;
	localparam logic [4:0] S_M1   = 5'd9;
	localparam logic [4:0] S_M2   = 5'd10;
	localparam logic [4:0] S_M3   = 5'd11;
	localparam logic [4:0] S_M4   = 5'd12;
	localparam logic [4:0] S_R0   = 5'd13;
	localparam logic [4:0] S_R1   = 5'd14;
	localparam logic [4:0] S_R2   = 5'd15;
	localparam logic [4:0] S_R3   = 5'd16;
	localparam logic [4:0] S_R4   = 5'd17;
	localparam logic [4:0] S_EU   = 5'd18;
	localparam logic [4:0] S_EUW  = 5'd19;
	localparam logic [4:0] S_DW   = 5'd20;
	localparam logic [4:0] S_FIN  = 5'd21;

	function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic signed [63:0] ext64(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic fits(input logic signed [63:0] v);
		logic signed [63:0] hi;
		hi = v >>> (WIDTH - 1);
		return (hi == 64'sd0) || (hi == -64'sd1);
	endfunction

	logic [4:0]         state_q;
	logic [4:0]         eu_ret_q;
	logic [4:0]         red_ret_q;
	logic [4:0]         dv_ret_q;
	logic [1:0]         red_cnt_q;
	logic [1:0]         st_q;
	rau_job_t           cur_q;
	logic signed [63:0] rn_q;
	logic signed [63:0] rd_q;
	logic signed [63:0] ex_q;
	logic signed [63:0] ey_q;
	logic signed [63:0] g_q;
	logic signed [63:0] l_q;
	logic signed [63:0] x_q;
	logic signed [32:0] t1_q;
	logic signed [32:0] t2_q;
	logic signed [32:0] mn_q;
	logic signed [32:0] md_q;
	logic signed [63:0] prod_q;
	logic               strobe_q;
	rau_out_t           res_q;
	logic               div_start_q;
	logic signed [63:0] div_dnd_q;
	logic signed [63:0] div_dsr_q;
	rau_div_req_t       dreq;
	rau_div_rsp_t       drsp;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic signed [63:0] abs_p;
	logic signed [63:0] y_val;
	logic signed [64:0] sum65;
	logic [1:0]         st_fin;

	assign dreq.start    = div_start_q;
	assign dreq.dividend = div_dnd_q;
	assign dreq.divisor  = div_dsr_q;

	rau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	assign job_take = (state_q == S_IDLE) && job_valid;
	assign strobe   = strobe_q;
	assign res      = res_q;

	always_comb begin
		case (state_q)
			S_A1: begin
				mul_a = ext33(cur_q.ad);
				mul_b = ext33(cur_q.bd);
			end
			S_A5: begin
				mul_a = ext33(cur_q.an);
				mul_b = t1_q;
			end
			S_A6: begin
				mul_a = ext33(cur_q.bn);
				mul_b = t2_q;
			end
			S_M2: begin
				mul_a = ext33(cur_q.an);
				mul_b = mn_q;
			end
			S_M3: begin
				mul_a = ext33(cur_q.ad);
				mul_b = md_q;
			end
			default: begin
				mul_a = 33'sd0;
				mul_b = 33'sd0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign abs_p = prod_q[63] ? -prod_q : prod_q;
	assign y_val = (cur_q.op == OP_SUB) ? -prod_q : prod_q;
	assign sum65 = {x_q[63], x_q} + {y_val[63], y_val};

	always_comb begin
		if (st_q != ST_OK) begin
			st_fin = st_q;
		end else if (!fits(rn_q) || !fits(rd_q)) begin
			st_fin = ST_OVF;
		end else begin
			st_fin = ST_OK;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p[63:0];
		case (state_q)
			S_IDLE: begin
				cur_q <= job;
			end
			S_DISP: begin
				if (cur_q.op == OP_ADD || cur_q.op == OP_SUB) begin
					ex_q <= ext64(cur_q.ad);
					ey_q <= ext64(cur_q.bd);
				end else if (cur_q.op == OP_DIV) begin
					rn_q <= ext64(cur_q.bd);
					rd_q <= ext64(cur_q.bn);
				end else begin
					mn_q <= ext33(cur_q.bn);
					md_q <= ext33(cur_q.bd);
				end
			end
			S_A1: begin
				g_q <= ex_q;
			end
			S_A2: begin
				div_dnd_q <= abs_p;
				div_dsr_q <= g_q;
			end
			S_A3: begin
				l_q       <= drsp.quo;
				div_dnd_q <= drsp.quo;
				div_dsr_q <= ext64(cur_q.ad);
			end
			S_A4: begin
				t1_q      <= drsp.quo[32:0];
				div_dnd_q <= l_q;
				div_dsr_q <= ext64(cur_q.bd);
			end
			S_A5: begin
				t2_q <= drsp.quo[32:0];
			end
			S_A6: begin
				x_q <= prod_q;
			end
			S_A7: begin
				rn_q <= sum65[63:0];
				rd_q <= l_q;
			end
			S_M1: begin
				mn_q <= rn_q[32:0];
				md_q <= rd_q[32:0];
			end
			S_M3: begin
				rn_q <= prod_q;
			end
			S_M4: begin
				rd_q <= prod_q;
			end
			S_R0: begin
				ex_q <= rn_q;
				ey_q <= rd_q;
			end
			S_R1: begin
				g_q <= ex_q;
				if (ex_q == -64'sd1) begin
					rn_q <= -rn_q;
					rd_q <= -rd_q;
				end
				div_dnd_q <= rn_q;
				div_dsr_q <= ex_q;
			end
			S_R2: begin
				rn_q      <= drsp.quo;
				div_dnd_q <= rd_q;
				div_dsr_q <= g_q;
			end
			S_R3: begin
				rd_q <= drsp.quo;
			end
			S_EU: begin
				if (ey_q == -64'sd1) begin
					ex_q <= ey_q;
					ey_q <= 64'sd0;
				end
				div_dnd_q <= ex_q;
				div_dsr_q <= ey_q;
			end
			S_EUW: begin
				if (drsp.done) begin
					ex_q <= ey_q;
					ey_q <= drsp.rem;
				end
			end
			S_FIN: begin
				res_q.status  <= st_fin;
				res_q.res_num <= (st_fin == ST_OK) ? rn_q[31:0] : 32'sd0;
				res_q.res_den <= (st_fin == ST_OK) ? rd_q[31:0] : 32'sd0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			eu_ret_q    <= S_IDLE;
			red_ret_q   <= S_IDLE;
			dv_ret_q    <= S_IDLE;
			red_cnt_q   <= 2'd0;
			st_q        <= ST_OK;
			strobe_q    <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			strobe_q    <= 1'b0;
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					st_q <= ST_OK;
					if (cur_q.zden) begin
						st_q    <= ST_ZDIV;
						state_q <= S_FIN;
					end else if (cur_q.op == OP_ADD || cur_q.op == OP_SUB) begin
						eu_ret_q <= S_A1;
						state_q  <= S_EU;
					end else if (cur_q.op == OP_DIV) begin
						red_cnt_q <= 2'd1;
						red_ret_q <= S_M1;
						state_q   <= S_R0;
					end else begin
						state_q <= S_M2;
					end
				end
				S_A1: state_q <= S_A2;
				S_A2: begin
					div_start_q <= 1'b1;
					dv_ret_q    <= S_A3;
					state_q     <= S_DW;
				end
				S_A3: begin
					div_start_q <= 1'b1;
					dv_ret_q    <= S_A4;
					state_q     <= S_DW;
				end
				S_A4: begin
					div_start_q <= 1'b1;
					dv_ret_q    <= S_A5;
					state_q     <= S_DW;
				end
				S_A5: state_q <= S_A6;
				S_A6: state_q <= S_A7;
				S_A7: begin
					if (sum65[64] != sum65[63]) begin
						st_q    <= ST_OVF;
						state_q <= S_FIN;
					end else begin
						red_cnt_q <= 2'd2;
						red_ret_q <= S_FIN;
						state_q   <= S_R0;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: begin
					red_cnt_q <= 2'd2;
					red_ret_q <= S_FIN;
					state_q   <= S_R0;
				end
				S_R0: begin
					eu_ret_q <= S_R1;
					state_q  <= S_EU;
				end
				S_R1: begin
					if (ex_q == 64'sd0) begin
						st_q    <= ST_ZDIV;
						state_q <= S_FIN;
					end else if (ex_q == -64'sd1) begin
						if (rn_q == I64_MIN || rd_q == I64_MIN) begin
							st_q    <= ST_OVF;
							state_q <= S_FIN;
						end else begin
							state_q <= S_R4;
						end
					end else begin
						div_start_q <= 1'b1;
						dv_ret_q    <= S_R2;
						state_q     <= S_DW;
					end
				end
				S_R2: begin
					div_start_q <= 1'b1;
					dv_ret_q    <= S_R3;
					state_q     <= S_DW;
				end
				S_R3: state_q <= S_R4;
				S_R4: begin
					if (red_cnt_q == 2'd1) begin
						state_q <= red_ret_q;
					end else begin
						red_cnt_q <= red_cnt_q - 2'd1;
						state_q   <= S_R0;
					end
				end
				S_EU: begin
					if (ey_q == 64'sd0) begin
						state_q <= eu_ret_q;
					end else if (ey_q != -64'sd1) begin
						div_start_q <= 1'b1;
						state_q     <= S_EUW;
					end
				end
				S_EUW: begin
					if (drsp.done) begin
						state_q <= S_EU;
					end
				end
				S_DW: begin
					if (drsp.done) begin
						state_q <= dv_ret_q;
					end
				end
				S_FIN: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/rational_arith_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the
// result by a gcd from Euclid's loop, flagging zero division and overflow.
// ----------------------------------------------------------------------------
//
//   Channel   Signals          Direction  Transfer
//   request   start/busy, req  in         accepted when start is high, busy low
//   result    strobe, res      out        one cycle per item, cannot be stalled
//
// A front end sign-extends the operands from WIDTH bits, classifies the
// item and places it in a two-entry queue, so up to two items can be taken
// while the back end is still working. The back end runs one item at a time.
// Its cost is set by the shared 64-bit divider: the sequencer waits on it for
// each Euclid step and every other divide, so items whose gcd chains are
// long take the longest. Reset clears the queue and the sequencer at once; no
// clearing pass is needed. busy is high only while the queue is full.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rau_pkg::rau_in_t  req,
	output logic              strobe,
	output rau_pkg::rau_out_t res
);
	import rau_pkg::*;

	logic     job_valid;
	logic     job_take;
	rau_job_t job;

	// Front end: operand extension, zero-denominator classification, queue.
	rau_front #(
		.WIDTH (WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	// Back end: the sequencer that computes and reduces each result.
	rau_back #(
		.WIDTH (WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.strobe    (strobe),
		.res       (res)
	);

	// The sequencer always returns to idle after a result, so two results
	// never come in adjacent cycles.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobe in two adjacent cycles");

	// A failed item carries zero in both result fields.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.status != ST_OK) |-> (res.res_num == 0 && res.res_den == 0))
		else $error("failed item with nonzero result fields");

	// The queue can only fill up through an item taken in the cycle before.
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted item");

endmodule

[verif/rau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Predicts each accepted item's result and compares it with what comes out.
// ----------------------------------------------------------------------------
module rau_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  rau_pkg::rau_in_t  req,
	input  logic              strobe,
	input  rau_pkg::rau_out_t res,
	output int                errors,
	output int                pending
);
	import rau_pkg::*;

	rau_out_t awaited_q[$];

	function automatic longint gcd_loop(longint x, longint y);
		longint t;
		while (y != 0) begin
			t = x;
			x = y;
			y = (y == -1) ? 64'sd0 : t % y;
		end
		return x;
	endfunction

	function automatic logic [1:0] reduce_frac(inout longint n, inout longint d);
		longint g;
		g = gcd_loop(n, d);
		if (g == 0) return ST_ZDIV;
		if (g == -1) begin
			if (n == I64_MIN || d == I64_MIN) return ST_OVF;
			n = -n;
			d = -d;
			return ST_OK;
		end
		n = n / g;
		d = d / g;
		return ST_OK;
	endfunction

	function automatic logic [1:0] reduce_twice(inout longint n, inout longint d);
		logic [1:0] s;
		s = reduce_frac(n, d);
		if (s != ST_OK) return s;
		return reduce_frac(n, d);
	endfunction

	function automatic logic fits32(longint v);
		return v >= -64'sd2147483648 && v <= 64'sd2147483647;
	endfunction

	function automatic rau_out_t predict_fraction(rau_in_t it);
		longint an, ad, bn, bd, rn, rd, g, p, l, x, y, mn, md;
		logic [1:0] st;
		rau_out_t o;
		an = it.a_num; ad = it.a_den; bn = it.b_num; bd = it.b_den;
		rn = 0; rd = 0;
		if (it.req_type == OP_ADD || it.req_type == OP_SUB) begin
			if (ad == 0 || bd == 0) begin
				st = ST_ZDIV;
			end else begin
				g = gcd_loop(ad, bd);
				p = ad * bd;
				if (p < 0) p = -p;
				l = p / g;
				x = an * (l / ad);
				y = bn * (l / bd);
				if (it.req_type == OP_SUB) y = -y;
				if ((x > 0 && y > 64'sh7fffffffffffffff - x) || (x < 0 && y < I64_MIN - x)) begin
					st = ST_OVF;
				end else begin
					rn = x + y;
					rd = l;
					st = reduce_twice(rn, rd);
				end
			end
		end else begin
			mn = bn; md = bd;
			st = ST_OK;
			if (it.req_type == OP_DIV) begin
				mn = bd;
				md = bn;
				st = reduce_frac(mn, md);
			end
			if (st == ST_OK) begin
				rn = an * mn;
				rd = ad * md;
				st = reduce_twice(rn, rd);
			end
		end
		if (st == ST_OK && (!fits32(rn) || !fits32(rd))) st = ST_OVF;
		if (st != ST_OK) begin
			rn = 0;
			rd = 0;
		end
		o.res_num = rn[31:0];
		o.res_den = rd[31:0];
		o.status  = st;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		rau_out_t want;
		if (arst_n) begin
			if (start && !busy) awaited_q.push_back(predict_fraction(req));
			if (strobe) begin
				if (awaited_q.size() == 0) begin
					report_mismatch("unexpected result, status", res.status, -1);
				end else begin
					want = awaited_q.pop_front();
					if (res.res_num !== want.res_num)
						report_mismatch("res_num", res.res_num, want.res_num);
					if (res.res_den !== want.res_den)
						report_mismatch("res_den", res.res_den, want.res_den);
					if (res.status !== want.status)
						report_mismatch("status", res.status, want.status);
				end
			end
		end
		pending = awaited_q.size();
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Directed corner fractions, then random items over several idling phases;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import rau_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	rau_in_t   req = '0;
	logic      strobe;
	rau_out_t  res;
	int        errors;
	int        pending;
	longint    cycles = 0;

	// Items with long gcd chains are slow, so the limit is loose.
	localparam longint CYCLE_LIMIT = 40_000_000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rational_arith_unit #(.WIDTH(32)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .strobe(strobe), .res(res)
	);

	rau_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.strobe(strobe), .res(res), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rational_arith_unit test failed");
			$finish;
		end
	end

	// Percentage of items after which the sender drops start and idles.
	int idle_pct = 0;

	// Present one item and hold it until the block takes it. start stays high
	// across back-to-back items so it never gets two assignments in one step.
	task automatic send_item(rau_in_t it);
		start <= 1'b1;
		req   <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			req   <= {2'($urandom), $urandom, $urandom, $urandom, $urandom};
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic rau_in_t make_item(logic [1:0] op, int an, int ad, int bn, int bd);
		rau_in_t it;
		it.req_type = op;
		it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
		return it;
	endfunction

	// Mostly small operands, which keep Euclid's chain short, with some full
	// range values and an occasional zero.
	function automatic int pick_operand();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8) return 0;
		if (sel < 60) return $signed($urandom_range(0, 200)) - 100;
		if (sel < 80) return $signed($urandom_range(0, 20000)) - 10000;
		if (sel < 86) return (sel[0]) ? 32'sh7fffffff : 32'sh80000000;
		return $urandom;
	endfunction

	initial begin
		logic [1:0] op;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: every operation, zero denominators, zero gcd,
		// negative gcd, extremes and results that overflow.
		send_item(make_item(OP_ADD, 1, 2, 1, 3));
		send_item(make_item(OP_SUB, 1, 2, 1, 2));
		send_item(make_item(OP_MUL, 2, 3, 3, 4));
		send_item(make_item(OP_DIV, 2, 3, 4, 9));
		send_item(make_item(OP_ADD, 1, 0, 1, 2));
		send_item(make_item(OP_SUB, 1, 2, 1, 0));
		send_item(make_item(OP_MUL, 5, 0, 3, 1));
		send_item(make_item(OP_MUL, -5, 0, 3, 1));
		send_item(make_item(OP_MUL, 0, 0, 7, 9));
		send_item(make_item(OP_DIV, 1, 2, 0, 0));
		send_item(make_item(OP_DIV, 3, 4, 0, 5));
		send_item(make_item(OP_DIV, 3, 4, 5, 0));
		send_item(make_item(OP_MUL, -1, 1, 1, 1));
		send_item(make_item(OP_MUL, 1, -1, -1, 1));
		send_item(make_item(OP_ADD, 32'sh7fffffff, 1, 32'sh7fffffff, 1));
		send_item(make_item(OP_SUB, 32'sh80000000, 1, 32'sh7fffffff, 1));
		send_item(make_item(OP_MUL, 32'sh80000000, 1, 32'sh80000000, 1));
		send_item(make_item(OP_DIV, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, -1));
		send_item(make_item(OP_ADD, 1, 32'sh7fffffff, 1, 32'sh7ffffffe));
		send_item(make_item(OP_SUB, -1, 32'sh80000000, 1, -3));
		send_item(make_item(OP_MUL, 32'sh7fffffff, -1, -1, 32'sh80000000));
		send_item(make_item(OP_DIV, 32'shffffffff, 32'shffffffff, 32'shffffffff, -1));

		// Let everything drain before the random phases begin. The bench first
		// waits so the checker has logged the last accepted item.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 69;
				2: idle_pct = 0;
				default: idle_pct = 36;
			endcase
			for (int n = 0; n < 135; n++) begin
				op = 2'($urandom_range(3));
				send_item(make_item(op, pick_operand(), pick_operand(),
					pick_operand(), pick_operand()));
				if (n == 60 && ph == 1) begin
					start <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("rational_arith_unit test passed");
		end else begin
			$display("rational_arith_unit test failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/rau_pkg.sv
rtl/rau_front.sv
rtl/rau_div.sv
rtl/rau_back.sv
rtl/rational_arith_unit.sv
verif/rau_checker.sv
verif/testbench.sv
